// File: sv/assert_macros.svh
// Assertion macros used by the checker file of the channel allocator.
// Each macro clocks on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication or any other property, sampled on every rising edge.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must hold in the cycle after a trigger.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

// File: sv/ppca_pkg.sv
// Package of the paired PWM channel allocator: sizes, codes and the structs
// passed between the table, the sequencer and the top level. No dependencies.
package ppca_pkg;

  localparam int NUM_CHANNELS = 16;
  localparam int NUM_PAIRS    = (NUM_CHANNELS + 1) / 2;
  localparam int CH_W         = (NUM_CHANNELS > 2) ? $clog2(NUM_CHANNELS) : 2;
  localparam int PAIR_W       = CH_W - 1;

  localparam int PIN_W  = 6;
  localparam int FREQ_W = 26;
  localparam int RES_W  = 5;
  localparam int FUNC_W = 2;
  localparam int OUT_W  = 4;
  localparam int CFG_W  = 6;

  localparam logic [CH_W-1:0] LAST_CH   = CH_W'(NUM_CHANNELS - 1);
  localparam logic [CH_W-1:0] PAIR_FLIP = CH_W'(1);

  localparam logic [PIN_W-1:0] MAX_PIN_RST = PIN_W'(33);
  localparam logic [RES_W-1:0] DEF_RES_RST = RES_W'(8);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_SETFREQ = 2'd2
  } func_e;

  typedef enum logic {
    REG_MAX_PIN = 1'b0,
    REG_DEF_RES = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic              own_we;
    logic [CH_W-1:0]   own_idx;
    logic [PIN_W-1:0]  own_pin;
    logic              pair_we;
    logic [PAIR_W-1:0] pair_idx;
    logic [FREQ_W-1:0] pair_freq;
    logic [RES_W-1:0]  pair_res;
  } tbl_wr_t;

  typedef struct packed {
    logic [PIN_W-1:0]  owner;
    logic              partner_busy;
    logic [FREQ_W-1:0] freq;
    logic [RES_W-1:0]  res;
  } tbl_rd_t;

  typedef struct packed {
    logic             success;
    logic [OUT_W-1:0] channel;
    logic             timer_programmed;
    logic             channel_freed;
    logic [OUT_W-1:0] freed_index;
  } result_t;

  // Channel index as reported on the result: its low four bits.
  function automatic logic [OUT_W-1:0] out_idx(logic [CH_W-1:0] idx);
    logic [CH_W+OUT_W-1:0] wide;
    wide = {{OUT_W{1'b0}}, idx};
    return wide[OUT_W-1:0];
  endfunction

  function automatic logic [PAIR_W-1:0] pair_of(logic [CH_W-1:0] idx);
    return idx[CH_W-1:1];
  endfunction

endpackage

// File: sv/paired_pwm_channel_allocator.sv
// Sequence: a request is accepted, the 16 channels are scanned one per cycle and a
// commit follows, which loads the result once the output register is free; a
// set-frequency request that changes the frequency of an owned in-range pin rescans.
// A new request is taken only after the commit, once the sequencer is back in idle.
// Reset clears the owner table, the sequencer and the output valid flag, and loads the
// register defaults (highest pin 33, resolution 8); the pair timers are not cleared.
module paired_pwm_channel_allocator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [ppca_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ppca_pkg::FUNC_W-1:0]   func_i,
  input  logic [ppca_pkg::PIN_W-1:0]    pin_i,
  input  logic [ppca_pkg::FREQ_W-1:0]   frequency_i,
  input  logic [ppca_pkg::RES_W-1:0]    resolution_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          success_o,
  output logic [ppca_pkg::OUT_W-1:0]    channel_o,
  output logic                          timer_programmed_o,
  output logic                          channel_freed_o,
  output logic [ppca_pkg::OUT_W-1:0]    freed_index_o
);

  logic [ppca_pkg::PIN_W-1:0] max_pin_q;
  logic [ppca_pkg::RES_W-1:0] def_res_q;
  logic                       seq_busy;
  logic                       out_free;
  logic                       res_load;
  logic                       out_valid_q;
  logic [ppca_pkg::CH_W-1:0]  rd_idx;
  ppca_pkg::tbl_rd_t          tbl_rd;
  ppca_pkg::tbl_wr_t          tbl_wr;
  ppca_pkg::result_t          res_new;
  ppca_pkg::result_t          result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_pin_q <= ppca_pkg::MAX_PIN_RST;
      def_res_q <= ppca_pkg::DEF_RES_RST;
    end else if (cfg_we_i) begin
      case (ppca_pkg::cfg_reg_e'(cfg_idx_i))
        ppca_pkg::REG_MAX_PIN: max_pin_q <= cfg_data_i[ppca_pkg::PIN_W-1:0];
        ppca_pkg::REG_DEF_RES: def_res_q <= cfg_data_i[ppca_pkg::RES_W-1:0];
        default: begin
          max_pin_q <= max_pin_q;
        end
      endcase
    end
  end

  ppca_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (rd_idx),
    .wr_i     (tbl_wr),
    .rd_o     (tbl_rd)
  );

  ppca_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (in_valid_i),
    .busy_o       (seq_busy),
    .func_i       (func_i),
    .pin_i        (pin_i),
    .frequency_i  (frequency_i),
    .resolution_i (resolution_i),
    .max_pin_i    (max_pin_q),
    .def_res_i    (def_res_q),
    .out_free_i   (out_free),
    .rd_idx_o     (rd_idx),
    .rd_i         (tbl_rd),
    .wr_o         (tbl_wr),
    .res_load_o   (res_load),
    .res_o        (res_new)
  );

  // The output register is free when it is empty or its held result is taken this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      result_q <= res_new;
    end
  end

  assign in_stall_o         = seq_busy;
  assign out_valid_o        = out_valid_q;
  assign success_o          = result_q.success;
  assign channel_o          = result_q.channel;
  assign timer_programmed_o = result_q.timer_programmed;
  assign channel_freed_o    = result_q.channel_freed;
  assign freed_index_o      = result_q.freed_index;

endmodule

// File: sv/ppca_table.sv
// Channel owner table and per-pair timer store with one read port.
// Depends on ppca_pkg.
module ppca_table (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [ppca_pkg::CH_W-1:0]    rd_idx_i,
  input  ppca_pkg::tbl_wr_t            wr_i,
  output ppca_pkg::tbl_rd_t            rd_o
);

  logic [ppca_pkg::PIN_W-1:0]  owner_q [ppca_pkg::NUM_CHANNELS];
  logic [ppca_pkg::FREQ_W-1:0] freq_q  [ppca_pkg::NUM_PAIRS];
  logic [ppca_pkg::RES_W-1:0]  res_q   [ppca_pkg::NUM_PAIRS];
  logic [ppca_pkg::NUM_CHANNELS-1:0] busy;
  logic [ppca_pkg::CH_W-1:0]   partner;
  logic [ppca_pkg::PAIR_W-1:0] rd_pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ppca_pkg::NUM_CHANNELS; i++) begin
        owner_q[i] <= '0;
      end
    end else if (wr_i.own_we) begin
      owner_q[wr_i.own_idx] <= wr_i.own_pin;
    end
  end

  // The timer store is only read for pairs that have a busy channel, and
  // such a pair was programmed when it became busy, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (wr_i.pair_we) begin
      freq_q[wr_i.pair_idx] <= wr_i.pair_freq;
      res_q[wr_i.pair_idx]  <= wr_i.pair_res;
    end
  end

  always_comb begin
    for (int i = 0; i < ppca_pkg::NUM_CHANNELS; i++) begin
      busy[i] = (owner_q[i] != '0);
    end
  end

  assign partner = rd_idx_i ^ ppca_pkg::PAIR_FLIP;
  assign rd_pair = ppca_pkg::pair_of(rd_idx_i);

  // With an odd channel count the last channel has no partner.
  assign rd_o.owner        = owner_q[rd_idx_i];
  assign rd_o.partner_busy = (partner <= ppca_pkg::LAST_CH) && busy[partner];
  assign rd_o.freq         = freq_q[rd_pair];
  assign rd_o.res          = res_q[rd_pair];

endmodule

// File: sv/ppca_seq.sv
// Request sequencer: scans the owner table one channel a cycle through a
// shared compare unit, then commits the decision. Depends on ppca_pkg.
module ppca_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          busy_o,
  input  logic [ppca_pkg::FUNC_W-1:0]   func_i,
  input  logic [ppca_pkg::PIN_W-1:0]    pin_i,
  input  logic [ppca_pkg::FREQ_W-1:0]   frequency_i,
  input  logic [ppca_pkg::RES_W-1:0]    resolution_i,
  input  logic [ppca_pkg::PIN_W-1:0]    max_pin_i,
  input  logic [ppca_pkg::RES_W-1:0]    def_res_i,
  input  logic                          out_free_i,
  output logic [ppca_pkg::CH_W-1:0]     rd_idx_o,
  input  ppca_pkg::tbl_rd_t             rd_i,
  output ppca_pkg::tbl_wr_t             wr_o,
  output logic                          res_load_o,
  output ppca_pkg::result_t             res_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Request payload.
  ppca_pkg::func_e             func_q, func_d;
  logic [ppca_pkg::PIN_W-1:0]  pin_q, pin_d;
  logic [ppca_pkg::FREQ_W-1:0] freq_q, freq_d;
  logic [ppca_pkg::RES_W-1:0]  res_q, res_d;
  logic [ppca_pkg::CH_W-1:0]   idx_q, idx_d;
  logic [ppca_pkg::CH_W-1:0]   own_idx_q, own_idx_d;
  logic [ppca_pkg::CH_W-1:0]   mat_idx_q, mat_idx_d;
  logic [ppca_pkg::CH_W-1:0]   emp_idx_q, emp_idx_d;
  logic [ppca_pkg::CH_W-1:0]   freed_idx_q, freed_idx_d;

  // Scan flags.
  logic in_range_q, in_range_d;
  logic rescan_q, rescan_d;
  logic own_hit_q, own_hit_d;
  logic own_fmatch_q, own_fmatch_d;
  logic mat_hit_q, mat_hit_d;
  logic emp_hit_q, emp_hit_d;
  logic freed_q, freed_d;

  logic                      slot_empty;
  logic                      freq_eq;
  logic                      res_eq;
  logic                      a_ok;
  logic                      a_prog;
  logic [ppca_pkg::CH_W-1:0] a_chan;

  // Shared compare unit on the table read port.
  assign slot_empty = (rd_i.owner == '0);
  assign freq_eq    = (rd_i.freq == freq_q);
  assign res_eq     = (rd_i.res == res_q);

  // Allocation outcome once the scan is over: a free channel beside a
  // matching busy partner wins over the first fully empty pair.
  always_comb begin
    a_ok   = 1'b0;
    a_prog = 1'b0;
    a_chan = '0;
    if (mat_hit_q) begin
      a_ok   = 1'b1;
      a_chan = mat_idx_q;
    end else if (emp_hit_q) begin
      a_ok   = 1'b1;
      a_prog = 1'b1;
      a_chan = emp_idx_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    func_d       = func_q;
    pin_d        = pin_q;
    freq_d       = freq_q;
    res_d        = res_q;
    idx_d        = idx_q;
    own_idx_d    = own_idx_q;
    mat_idx_d    = mat_idx_q;
    emp_idx_d    = emp_idx_q;
    freed_idx_d  = freed_idx_q;
    in_range_d   = in_range_q;
    rescan_d     = rescan_q;
    own_hit_d    = own_hit_q;
    own_fmatch_d = own_fmatch_q;
    mat_hit_d    = mat_hit_q;
    emp_hit_d    = emp_hit_q;
    freed_d      = freed_q;
    wr_o         = '0;
    res_load_o   = 1'b0;
    res_o        = '0;

    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          func_d       = ppca_pkg::func_e'(func_i);
          pin_d        = pin_i;
          freq_d       = frequency_i;
          res_d        = (func_i == ppca_pkg::FUNC_SETFREQ) ? def_res_i : resolution_i;
          in_range_d   = (pin_i != '0) && (pin_i <= max_pin_i);
          idx_d        = '0;
          rescan_d     = 1'b0;
          own_hit_d    = 1'b0;
          own_fmatch_d = 1'b0;
          mat_hit_d    = 1'b0;
          emp_hit_d    = 1'b0;
          freed_d      = 1'b0;
          state_d      = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (!rescan_q && !own_hit_q && (pin_q != '0) && (rd_i.owner == pin_q)) begin
          own_hit_d    = 1'b1;
          own_idx_d    = idx_q;
          own_fmatch_d = freq_eq;
        end
        if (slot_empty && rd_i.partner_busy && freq_eq && res_eq && !mat_hit_q) begin
          mat_hit_d = 1'b1;
          mat_idx_d = idx_q;
        end
        if (slot_empty && !rd_i.partner_busy && !emp_hit_q) begin
          emp_hit_d = 1'b1;
          emp_idx_d = idx_q & ~ppca_pkg::PAIR_FLIP;
        end
        if (idx_q == ppca_pkg::LAST_CH) begin
          state_d = ST_COMMIT;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      ST_COMMIT: begin
        if (out_free_i) begin
          res_load_o = 1'b1;
          state_d    = ST_IDLE;
          case (func_q)
            ppca_pkg::FUNC_ALLOC: begin
              if (in_range_q) begin
                if (own_hit_q) begin
                  res_o.success = 1'b1;
                  res_o.channel = ppca_pkg::out_idx(own_idx_q);
                end else if (a_ok) begin
                  wr_o.own_we            = 1'b1;
                  wr_o.own_idx           = a_chan;
                  wr_o.own_pin           = pin_q;
                  wr_o.pair_we           = a_prog;
                  wr_o.pair_idx          = ppca_pkg::pair_of(a_chan);
                  wr_o.pair_freq         = freq_q;
                  wr_o.pair_res          = res_q;
                  res_o.success          = 1'b1;
                  res_o.channel          = ppca_pkg::out_idx(a_chan);
                  res_o.timer_programmed = a_prog;
                end
              end
            end

            ppca_pkg::FUNC_RELEASE: begin
              if (own_hit_q) begin
                wr_o.own_we         = 1'b1;
                wr_o.own_idx        = own_idx_q;
                res_o.success       = 1'b1;
                res_o.channel       = ppca_pkg::out_idx(own_idx_q);
                res_o.channel_freed = 1'b1;
                res_o.freed_index   = ppca_pkg::out_idx(own_idx_q);
              end
            end

            ppca_pkg::FUNC_SETFREQ: begin
              if (own_hit_q && own_fmatch_q) begin
                res_o.success = 1'b1;
                res_o.channel = ppca_pkg::out_idx(own_idx_q);
              end else if (own_hit_q) begin
                // Detach the channel; with the pin in range, a fresh scan then sees it as empty.
                wr_o.own_we = 1'b1;
                wr_o.own_idx = own_idx_q;
                freed_d     = 1'b1;
                freed_idx_d = own_idx_q;
                if (in_range_q) begin
                  res_load_o = 1'b0;
                  rescan_d   = 1'b1;
                  own_hit_d  = 1'b0;
                  mat_hit_d  = 1'b0;
                  emp_hit_d  = 1'b0;
                  idx_d      = '0;
                  state_d    = ST_SCAN;
                end else begin
                  res_o.channel_freed = 1'b1;
                  res_o.freed_index   = ppca_pkg::out_idx(own_idx_q);
                end
              end else begin
                res_o.channel_freed = freed_q;
                res_o.freed_index   = freed_q ? ppca_pkg::out_idx(freed_idx_q) : '0;
                if (in_range_q && a_ok) begin
                  wr_o.own_we            = 1'b1;
                  wr_o.own_idx           = a_chan;
                  wr_o.own_pin           = pin_q;
                  wr_o.pair_we           = a_prog;
                  wr_o.pair_idx          = ppca_pkg::pair_of(a_chan);
                  wr_o.pair_freq         = freq_q;
                  wr_o.pair_res          = res_q;
                  res_o.success          = 1'b1;
                  res_o.channel          = ppca_pkg::out_idx(a_chan);
                  res_o.timer_programmed = a_prog;
                end
              end
            end

            default: begin
              res_o = '0;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      in_range_q   <= 1'b0;
      rescan_q     <= 1'b0;
      own_hit_q    <= 1'b0;
      own_fmatch_q <= 1'b0;
      mat_hit_q    <= 1'b0;
      emp_hit_q    <= 1'b0;
      freed_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      in_range_q   <= in_range_d;
      rescan_q     <= rescan_d;
      own_hit_q    <= own_hit_d;
      own_fmatch_q <= own_fmatch_d;
      mat_hit_q    <= mat_hit_d;
      emp_hit_q    <= emp_hit_d;
      freed_q      <= freed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    pin_q       <= pin_d;
    freq_q      <= freq_d;
    res_q       <= res_d;
    idx_q       <= idx_d;
    own_idx_q   <= own_idx_d;
    mat_idx_q   <= mat_idx_d;
    emp_idx_q   <= emp_idx_d;
    freed_idx_q <= freed_idx_d;
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign rd_idx_o = idx_q;

endmodule

// File: sv/ppca_checker.sv
// Port-level checker for the channel allocator, bound to the top level.
// Depends on assert_macros.svh and ppca_pkg.
`include "assert_macros.svh"

module ppca_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          cfg_idx_i,
  input logic [ppca_pkg::CFG_W-1:0]    cfg_data_i,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [ppca_pkg::FUNC_W-1:0]   func_i,
  input logic [ppca_pkg::PIN_W-1:0]    pin_i,
  input logic [ppca_pkg::FREQ_W-1:0]   frequency_i,
  input logic [ppca_pkg::RES_W-1:0]    resolution_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          success_o,
  input logic [ppca_pkg::OUT_W-1:0]    channel_o,
  input logic                          timer_programmed_o,
  input logic                          channel_freed_o,
  input logic [ppca_pkg::OUT_W-1:0]    freed_index_o
);

  // An accepted request keeps the block busy while the channels are scanned.
  `ASSERT_NEXT(busy_after_req, in_valid_i && !in_stall_o, in_stall_o, "request taken while scanning")

  // A held result is not dropped.
  `ASSERT_NEXT(out_hold, out_valid_o && out_stall_i, out_valid_o, "stalled result lost")

  `ASSERT_PROP(chan_zero_on_fail, out_valid_o && !success_o |-> channel_o == '0, "channel set on failure")

  `ASSERT_PROP(freed_idx_zero, out_valid_o && !channel_freed_o |-> freed_index_o == '0, "freed index without free")

  // A timer is only programmed for the lower channel of an empty pair.
  `ASSERT_PROP(prog_even_chan, out_valid_o && timer_programmed_o |-> success_o && !channel_o[0], "timer on odd channel")

endmodule

bind paired_pwm_channel_allocator ppca_checker u_checker (.*);

// File: dv/paired_pwm_channel_allocator_test.sv
// Self-checking testbench of the paired PWM channel allocator: a scoreboard class
// predicts each result, and plain tasks drive requests and register writes.
// Depends on ppca_pkg and the paired_pwm_channel_allocator top level.
module paired_pwm_channel_allocator_test;

  localparam logic [ppca_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int MAX_FREQ = 40000000;
  localparam int MAX_RES = 20;
  localparam int PRINT_LIMIT = 40;

  class alloc_scoreboard;
    logic [ppca_pkg::PIN_W-1:0]  owner [ppca_pkg::NUM_CHANNELS];
    logic [ppca_pkg::FREQ_W-1:0] timer_freq [ppca_pkg::NUM_PAIRS];
    logic [ppca_pkg::RES_W-1:0]  timer_res [ppca_pkg::NUM_PAIRS];
    logic [ppca_pkg::PIN_W-1:0]  max_pin;
    logic [ppca_pkg::RES_W-1:0]  def_res;
    ppca_pkg::result_t expected_q [$];
    int errors, requests, results, programmed, freed, refused;

    function new();
      foreach (owner[i]) owner[i] = '0;
      foreach (timer_freq[i]) timer_freq[i] = '0;
      foreach (timer_res[i]) timer_res[i] = '0;
      max_pin = ppca_pkg::MAX_PIN_RST;
      def_res = ppca_pkg::DEF_RES_RST;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function int owner_of(logic [ppca_pkg::PIN_W-1:0] pin);
      if (pin == 0) return -1;
      for (int i = 0; i < ppca_pkg::NUM_CHANNELS; i++) if (owner[i] == pin) return i;
      return -1;
    endfunction

    // Own channel first, then a free channel beside a busy partner on the same timer
    // setting, then the lower channel of the first wholly empty pair.
    function int claim_channel(logic [ppca_pkg::PIN_W-1:0] pin,
                               logic [ppca_pkg::FREQ_W-1:0] freq,
                               logic [ppca_pkg::RES_W-1:0] res, output bit prog);
      int found;
      int spare;
      int mate;
      bit mate_busy;
      prog = 1'b0;
      spare = -1;
      if (pin < 1 || pin > max_pin) return -1;
      found = owner_of(pin);
      if (found >= 0) return found;
      for (int i = 0; i < ppca_pkg::NUM_CHANNELS; i++) begin
        if (owner[i] != 0) continue;
        mate = i ^ 1;
        mate_busy = mate < ppca_pkg::NUM_CHANNELS && owner[mate] != 0;
        if (mate_busy) begin
          if (timer_freq[i/2] == freq && timer_res[i/2] == res) begin
            owner[i] = pin;
            return i;
          end
        end else if (spare < 0) begin
          spare = i & ~1;
        end
      end
      if (spare >= 0) begin
        owner[spare] = pin;
        timer_freq[spare/2] = freq;
        timer_res[spare/2] = res;
        prog = 1'b1;
      end
      return spare;
    endfunction

    task note_request(logic [ppca_pkg::FUNC_W-1:0] func, logic [ppca_pkg::PIN_W-1:0] pin,
                      logic [ppca_pkg::FREQ_W-1:0] freq, logic [ppca_pkg::RES_W-1:0] res);
      ppca_pkg::result_t r;
      int c;
      int got;
      bit prog;
      r = '0;
      prog = 1'b0;
      case (func)
        ppca_pkg::FUNC_ALLOC: begin
          c = claim_channel(pin, freq, res, prog);
          if (c >= 0) begin
            r.success = 1'b1;
            r.channel = ppca_pkg::OUT_W'(c);
          end
        end
        ppca_pkg::FUNC_RELEASE: begin
          c = owner_of(pin);
          if (c >= 0) begin
            owner[c] = '0;
            r.success = 1'b1;
            r.channel = ppca_pkg::OUT_W'(c);
            r.channel_freed = 1'b1;
            r.freed_index = ppca_pkg::OUT_W'(c);
          end
        end
        ppca_pkg::FUNC_SETFREQ: begin
          c = owner_of(pin);
          if (c >= 0 && timer_freq[c/2] == freq) begin
            r.success = 1'b1;
            r.channel = ppca_pkg::OUT_W'(c);
          end else begin
            // The old channel is reported as freed even if the new claim fails.
            if (c >= 0) begin
              owner[c] = '0;
              r.channel_freed = 1'b1;
              r.freed_index = ppca_pkg::OUT_W'(c);
            end
            got = claim_channel(pin, freq, def_res, prog);
            if (got >= 0) begin
              r.success = 1'b1;
              r.channel = ppca_pkg::OUT_W'(got);
            end
          end
        end
        default: ;
      endcase
      r.timer_programmed = prog;
      requests++;
      if (prog) programmed++;
      if (r.channel_freed) freed++;
      if (!r.success) refused++;
      expected_q.push_back(r);
    endtask

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("MISMATCH: %s", msg);
    endtask

    task check_result(ppca_pkg::result_t got);
      ppca_pkg::result_t want;
      results++;
      if (expected_q.size() == 0) begin
        report($sformatf("result %0d arrived with no request outstanding", results));
        return;
      end
      want = expected_q.pop_front();
      if (got.success !== want.success)
        report($sformatf("result %0d: success %b, expected %b",
                         results, got.success, want.success));
      if (got.channel !== want.channel)
        report($sformatf("result %0d: channel %0d, expected %0d",
                         results, got.channel, want.channel));
      if (got.timer_programmed !== want.timer_programmed)
        report($sformatf("result %0d: timer_programmed %b, expected %b",
                         results, got.timer_programmed, want.timer_programmed));
      if (got.channel_freed !== want.channel_freed)
        report($sformatf("result %0d: channel_freed %b, expected %b",
                         results, got.channel_freed, want.channel_freed));
      if (got.freed_index !== want.freed_index)
        report($sformatf("result %0d: freed_index %0d, expected %0d",
                         results, got.freed_index, want.freed_index));
    endtask
  endclass

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_we_i = 1'b0;
  logic                              cfg_idx_i = 1'b0;
  logic [ppca_pkg::CFG_W-1:0]        cfg_data_i = '0;
  logic                              in_valid_i = 1'b0;
  logic                              in_stall_o;
  logic [ppca_pkg::FUNC_W-1:0]       func_i = '0;
  logic [ppca_pkg::PIN_W-1:0]        pin_i = '0;
  logic [ppca_pkg::FREQ_W-1:0]       frequency_i = '0;
  logic [ppca_pkg::RES_W-1:0]        resolution_i = ppca_pkg::RES_W'(1);
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic                              success_o;
  logic [ppca_pkg::OUT_W-1:0]        channel_o;
  logic                              timer_programmed_o;
  logic                              channel_freed_o;
  logic [ppca_pkg::OUT_W-1:0]        freed_index_o;

  alloc_scoreboard sb = new();
  ppca_pkg::result_t seen;
  int  sent = 0;
  bit  steady_tx = 1'b0;
  bit  steady_rx = 1'b0;
  int  stall_left = 0;

  paired_pwm_channel_allocator dut (.*);

  always #2 clk_i = ~clk_i;

  // Result side: the stall drawn after each result is held until the next result
  // has been waiting that many cycles, so stalls land on live results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen.success = success_o;
        seen.channel = channel_o;
        seen.timer_programmed = timer_programmed_o;
        seen.channel_freed = channel_freed_o;
        seen.freed_index = freed_index_o;
        sb.check_result(seen);
        if (sb.results % 32 == 0) steady_rx = ($urandom_range(0, 3) == 0);
        stall_left = steady_rx ? 0 : $urandom_range(0, 12);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  // Called at a rising edge; returns at the edge that accepted the request.
  task automatic send(logic [ppca_pkg::FUNC_W-1:0] f, logic [ppca_pkg::PIN_W-1:0] p,
                      logic [ppca_pkg::FREQ_W-1:0] fr, logic [ppca_pkg::RES_W-1:0] r);
    int gap;
    if (sent % 32 == 0) steady_tx = ($urandom_range(0, 3) == 0);
    gap = steady_tx ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    pin_i <= p;
    frequency_i <= fr;
    resolution_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(f, p, fr, r);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic configure(int max_pin, int def_res);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= ppca_pkg::REG_MAX_PIN;
    cfg_data_i <= ppca_pkg::CFG_W'(max_pin);
    @(posedge clk_i);
    sb.max_pin = ppca_pkg::PIN_W'(max_pin);
    cfg_idx_i <= ppca_pkg::REG_DEF_RES;
    cfg_data_i <= ppca_pkg::CFG_W'(def_res);
    @(posedge clk_i);
    sb.def_res = ppca_pkg::RES_W'(def_res);
    cfg_we_i <= 1'b0;
  endtask

  // A few frequencies and resolutions recur within a phase so that partners
  // share timers; the rest are drawn over the whole range.
  task automatic run_phase(int count);
    logic [ppca_pkg::FREQ_W-1:0] tone [4];
    logic [ppca_pkg::RES_W-1:0]  depth [4];
    logic [ppca_pkg::FUNC_W-1:0] f;
    logic [ppca_pkg::PIN_W-1:0]  p;
    logic [ppca_pkg::FREQ_W-1:0] fr;
    logic [ppca_pkg::RES_W-1:0]  r;
    int pick;
    tone[0] = ppca_pkg::FREQ_W'(MAX_FREQ);
    tone[1] = ppca_pkg::FREQ_W'($urandom_range(0, MAX_FREQ));
    tone[2] = ppca_pkg::FREQ_W'($urandom_range(0, 1000));
    tone[3] = ppca_pkg::FREQ_W'($urandom_range(0, MAX_FREQ));
    depth[0] = sb.def_res;
    depth[1] = ppca_pkg::RES_W'(8);
    depth[2] = ppca_pkg::RES_W'(MAX_RES);
    depth[3] = ppca_pkg::RES_W'($urandom_range(1, MAX_RES));
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) f = ppca_pkg::FUNC_ALLOC;
      else if (pick < 70) f = ppca_pkg::FUNC_RELEASE;
      else if (pick < 98) f = ppca_pkg::FUNC_SETFREQ;
      else f = FUNC_UNUSED;
      pick = $urandom_range(0, 99);
      if (pick < 85) p = ppca_pkg::PIN_W'($urandom_range(1, sb.max_pin));
      else if (pick < 90) p = '0;
      else p = ppca_pkg::PIN_W'($urandom_range(0, 63));
      fr = ($urandom_range(0, 4) == 0) ? ppca_pkg::FREQ_W'($urandom_range(0, MAX_FREQ))
                                       : tone[$urandom_range(0, 3)];
      r = ($urandom_range(0, 4) == 0) ? ppca_pkg::RES_W'($urandom_range(1, MAX_RES))
                                      : depth[$urandom_range(0, 3)];
      if ($urandom_range(0, 59) == 0) drain();
      send(f, p, fr, r);
    end
  endtask

  initial begin
    int stale;
    logic [ppca_pkg::PIN_W-1:0]  stale_pin;
    logic [ppca_pkg::FREQ_W-1:0] stale_freq;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pin zero, pins beyond the limit, then a pair filled by partner matching.
    send(ppca_pkg::FUNC_ALLOC, 0, 1000, 8);
    send(ppca_pkg::FUNC_ALLOC, 34, 1000, 8);
    send(ppca_pkg::FUNC_ALLOC, 63, 1000, 8);
    send(ppca_pkg::FUNC_ALLOC, 33, MAX_FREQ, 20);
    send(ppca_pkg::FUNC_ALLOC, 33, 5, 3);
    send(ppca_pkg::FUNC_ALLOC, 1, MAX_FREQ, 20);
    send(ppca_pkg::FUNC_ALLOC, 2, 0, 1);
    send(ppca_pkg::FUNC_ALLOC, 3, 0, 2);
    send(ppca_pkg::FUNC_ALLOC, 4, 0, 1);
    // Set-frequency: unchanged keeps, changed frees and claims again.
    send(ppca_pkg::FUNC_SETFREQ, 33, MAX_FREQ, 1);
    send(ppca_pkg::FUNC_SETFREQ, 2, 33554431, 16);
    send(ppca_pkg::FUNC_SETFREQ, 5, 33554431, 7);
    send(ppca_pkg::FUNC_RELEASE, 1, 0, 1);
    send(ppca_pkg::FUNC_RELEASE, 1, 0, 1);
    send(ppca_pkg::FUNC_RELEASE, 0, 0, 1);
    send(ppca_pkg::FUNC_SETFREQ, 0, 1000, 8);
    send(FUNC_UNUSED, 33, 1000, 8);
    send(ppca_pkg::FUNC_ALLOC, 6, 12345678, 20);
    // Distinct timer settings use up the empty pairs, so the last claims fail.
    for (int k = 10; k < 16; k++)
      send(ppca_pkg::FUNC_ALLOC, ppca_pkg::PIN_W'(k), ppca_pkg::FREQ_W'(k * 1000), 12);

    run_phase(300);
    configure(63, 20);
    run_phase(300);

    // With the pin limit at one, channels held by higher pins can only keep
    // their frequency; a change frees them and the new claim is refused.
    configure(1, 1);
    stale = -1;
    for (int i = 0; i < ppca_pkg::NUM_CHANNELS; i++) if (sb.owner[i] > sb.max_pin) stale = i;
    if (stale >= 0) begin
      stale_pin = sb.owner[stale];
      stale_freq = sb.timer_freq[stale/2];
      send(ppca_pkg::FUNC_SETFREQ, stale_pin, stale_freq, 1);
      send(ppca_pkg::FUNC_SETFREQ, stale_pin,
           (stale_freq == '0) ? ppca_pkg::FREQ_W'(1) : stale_freq - 1'b1, 1);
    end
    run_phase(150);

    configure($urandom_range(2, 62), $urandom_range(1, MAX_RES));
    run_phase(270);

    in_valid_i <= 1'b0;
    for (int w = 0; w < 5000 && sb.pending() != 0; w++) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));

    $display("Sent %0d requests across four register settings; %0d results checked.",
             sb.requests, sb.results);
    $display("Timers programmed %0d times, channels freed %0d times, %0d refusals.",
             sb.programmed, sb.freed, sb.refused);
    if (sb.errors == 0) begin
      $display("paired_pwm_channel_allocator_test OK");
    end else begin
      $display("paired_pwm_channel_allocator_test NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", sb.pending());
    $display("paired_pwm_channel_allocator_test NOT OK");
    $finish;
  end

endmodule
